FILE: rtl/core/cell_store_undo_redo_journal_assert.svh
// Assertion macros shared by the cell store RTL.
`ifndef CELL_STORE_UNDO_REDO_JOURNAL_ASSERT_SVH
`define CELL_STORE_UNDO_REDO_JOURNAL_ASSERT_SVH

// Overlapping implication, checked while out of reset.
`define CSURJ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("cell store assertion failed");

// Non-overlapping implication, checked while out of reset.
`define CSURJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("cell store assertion failed");

`endif

FILE: rtl/core/csurj_pkg.sv
package csurj_pkg;

    localparam int BLOCK_W = 8;
    localparam int TURN_W  = 2;
    localparam int COUNT_W = 9;

    // Operation codes of a command word.
    typedef enum logic [1:0] {
        FUNC_PLACE  = 2'd0,
        FUNC_ROTATE = 2'd1,
        FUNC_UNDO   = 2'd2,
        FUNC_REDO   = 2'd3
    } func_t;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_NONE  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

    typedef struct packed {
        func_t        func;
        logic [3:0]   col;
        logic [1:0]   row;
        logic [3:0]   tab;
        logic [BLOCK_W-1:0] block_code;
    } cmd_word_t;

    typedef struct packed {
        status_t            status;
        logic [BLOCK_W-1:0] cell_block;
        logic [TURN_W-1:0]  cell_rotation;
        logic [COUNT_W-1:0] history_count;
        logic [COUNT_W-1:0] history_position;
    } res_word_t;

    // Contents of one grid cell.
    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [TURN_W-1:0]  turn;
    } cell_val_t;

endpackage

FILE: rtl/core/cell_store_undo_redo_journal.sv
// Cell store with an undo/redo journal.
//
// A command word is taken on cmd at a rising edge where start is high and
// busy is low. Place writes a block code with rotation zero, rotate turns an
// occupied cell by a quarter, undo and redo step through the edit journal.
// Each command gives exactly one result word on result, marked by done for
// a single cycle; the receiver cannot stall it.
// The accepting edge loads the command and reads the grid memory and the
// journal memory into registers; the execute state writes them back, and
// done is registered from the execute state. busy is high during the execute
// state and low again while done is shown, so the next command can be taken.
// Reset: the counters clear at once, then a clearing pass writes zero to
// every grid cell, one a cycle, with busy held high.
// The journal keeps JOURNAL_DEPTH entries; when full, the oldest is dropped.

`include "cell_store_undo_redo_journal_assert.svh"

module cell_store_undo_redo_journal #(
    parameter int GRID_COLS     = 16,
    parameter int GRID_ROWS     = 4,
    parameter int GRID_TABS     = 16,
    parameter int JOURNAL_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  csurj_pkg::cmd_word_t  cmd,
    output logic                  done,
    output csurj_pkg::res_word_t  result
);
    import csurj_pkg::*;

    localparam int CELLS = GRID_COLS * GRID_ROWS * GRID_TABS;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SW    = $clog2(JOURNAL_DEPTH);
    localparam int JCW   = $clog2(JOURNAL_DEPTH + 1);
    localparam int SUMW  = JCW + 1;

    typedef struct packed {
        logic [CW-1:0] cell_idx;
        cell_val_t     old_val;
        cell_val_t     new_val;
    } jentry_t;

    // Memories.
    cell_val_t grid_mem [CELLS];
    jentry_t   jrn_mem  [JOURNAL_DEPTH];

    state_t          state_reg, state_next;
    logic [CW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [JCW-1:0]  fill_reg, fill_next;
    logic [JCW-1:0]  cursor_reg, cursor_next;
    logic [SW-1:0]   oldest_reg, oldest_next;
    logic            done_reg;
    res_word_t       result_reg, result_next;

    cmd_word_t       op_reg;
    logic [CW-1:0]   cell_reg;
    logic            oor_reg;
    cell_val_t       grid_q_reg;
    jentry_t         jrn_q_reg;

    logic            accept, clearing, exec;
    logic            oor_in;
    logic [CW-1:0]   cell_in;
    logic [JCW-1:0]  rd_off;
    logic [SUMW-1:0] rd_sum, wr_sum;
    logic [SW-1:0]   rd_slot, wr_slot, oldest_inc;

    logic            edit_grid_we, edit_jrn_we;
    logic [CW-1:0]   edit_grid_addr;
    cell_val_t       edit_grid_data;
    jentry_t         edit_jrn_data;
    cell_val_t       new_val;

    logic            grid_we;
    logic [CW-1:0]   grid_waddr;
    cell_val_t       grid_wdata;

    // Next state of the controller.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        busy     = 1'b1;
        clearing = 1'b0;
        exec     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign accept       = start && !busy;
    assign clr_cnt_next = clr_cnt_reg + CW'(1);

    // Address decode of the incoming word.
    always_comb
    begin
        oor_in  = (32'(cmd.col) >= GRID_COLS) || (32'(cmd.row) >= GRID_ROWS) ||
                  (32'(cmd.tab) >= GRID_TABS);
        cell_in = CW'(32'(cmd.col) + 32'(cmd.row) * GRID_COLS +
                      32'(cmd.tab) * (GRID_COLS * GRID_ROWS));
    end

    // Ring slots: read slot for undo or redo, write slot for a new edit.
    always_comb
    begin
        rd_off  = (cmd.func == FUNC_UNDO) ? (cursor_reg - JCW'(1)) : cursor_reg;
        rd_sum  = SUMW'(oldest_reg) + SUMW'(rd_off);
        rd_slot = (rd_sum >= SUMW'(JOURNAL_DEPTH)) ?
                  SW'(rd_sum - SUMW'(JOURNAL_DEPTH)) : SW'(rd_sum);
        wr_sum  = SUMW'(oldest_reg) + SUMW'(cursor_reg);
        wr_slot = (wr_sum >= SUMW'(JOURNAL_DEPTH)) ?
                  SW'(wr_sum - SUMW'(JOURNAL_DEPTH)) : SW'(wr_sum);
        oldest_inc = (oldest_reg == SW'(JOURNAL_DEPTH - 1)) ?
                     '0 : (oldest_reg + SW'(1));
    end

    // Execute cycle: work out the writes, counters and result word.
    always_comb
    begin
        edit_grid_we   = 1'b0;
        edit_jrn_we    = 1'b0;
        edit_grid_addr = cell_reg;
        edit_grid_data = '0;
        new_val        = '0;
        edit_jrn_data  = '0;
        fill_next      = fill_reg;
        cursor_next    = cursor_reg;
        oldest_next    = oldest_reg;
        result_next    = '0;
        result_next.status = STAT_DONE;

        case (op_reg.func)
            FUNC_UNDO:
            begin
                if (cursor_reg == '0)
                begin
                    result_next.status = STAT_NONE;
                end
                else
                begin
                    cursor_next    = cursor_reg - JCW'(1);
                    edit_grid_we   = 1'b1;
                    edit_grid_addr = jrn_q_reg.cell_idx;
                    edit_grid_data = jrn_q_reg.old_val;
                    result_next.cell_block    = jrn_q_reg.old_val.block;
                    result_next.cell_rotation = jrn_q_reg.old_val.turn;
                end
            end
            FUNC_REDO:
            begin
                if (cursor_reg >= fill_reg)
                begin
                    result_next.status = STAT_NONE;
                end
                else
                begin
                    cursor_next    = cursor_reg + JCW'(1);
                    edit_grid_we   = 1'b1;
                    edit_grid_addr = jrn_q_reg.cell_idx;
                    edit_grid_data = jrn_q_reg.new_val;
                    result_next.cell_block    = jrn_q_reg.new_val.block;
                    result_next.cell_rotation = jrn_q_reg.new_val.turn;
                end
            end
            FUNC_PLACE, FUNC_ROTATE:
            begin
                if (oor_reg)
                begin
                    result_next.status = STAT_RANGE;
                end
                else if (op_reg.func == FUNC_ROTATE && grid_q_reg.block == '0)
                begin
                    result_next.status        = STAT_EMPTY;
                    result_next.cell_block    = grid_q_reg.block;
                    result_next.cell_rotation = grid_q_reg.turn;
                end
                else
                begin
                    if (op_reg.func == FUNC_PLACE)
                    begin
                        new_val.block = op_reg.block_code;
                        new_val.turn  = '0;
                    end
                    else
                    begin
                        new_val.block = grid_q_reg.block;
                        new_val.turn  = grid_q_reg.turn + TURN_W'(1);
                    end
                    // Log the edit; a full journal overwrites its oldest entry.
                    edit_jrn_we            = 1'b1;
                    edit_jrn_data.cell_idx = cell_reg;
                    edit_jrn_data.old_val  = grid_q_reg;
                    edit_jrn_data.new_val  = new_val;
                    if (cursor_reg == JCW'(JOURNAL_DEPTH))
                    begin
                        oldest_next = oldest_inc;
                        fill_next   = JCW'(JOURNAL_DEPTH);
                        cursor_next = JCW'(JOURNAL_DEPTH);
                    end
                    else
                    begin
                        fill_next   = cursor_reg + JCW'(1);
                        cursor_next = cursor_reg + JCW'(1);
                    end
                    edit_grid_we   = 1'b1;
                    edit_grid_data = new_val;
                    result_next.cell_block    = new_val.block;
                    result_next.cell_rotation = new_val.turn;
                end
            end
            default:
            begin
                result_next.status = STAT_NONE;
            end
        endcase

        result_next.history_count    = COUNT_W'(fill_next);
        result_next.history_position = COUNT_W'(cursor_next);
    end

    // Grid write port: clearing pass or execute cycle.
    always_comb
    begin
        grid_we    = clearing || (exec && edit_grid_we);
        grid_waddr = clearing ? clr_cnt_reg : edit_grid_addr;
        grid_wdata = clearing ? cell_val_t'('0) : edit_grid_data;
    end

    // Grid memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        grid_q_reg <= grid_mem[cell_in];
    end

    // Journal memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (exec && edit_jrn_we)
        begin
            jrn_mem[wr_slot] <= edit_jrn_data;
        end
        jrn_q_reg <= jrn_mem[rd_slot];
    end

    // Command capture and result word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= cmd;
            cell_reg <= cell_in;
            oor_reg  <= oor_in;
        end
        if (exec)
        begin
            result_reg <= result_next;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            fill_reg    <= '0;
            cursor_reg  <= '0;
            oldest_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_next;
            end
            if (exec)
            begin
                fill_reg   <= fill_next;
                cursor_reg <= cursor_next;
                oldest_reg <= oldest_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks.
    `CSURJ_ASSERT_IMPLY(a_result_latency, clk, rst_n, start && !busy, ##2 done)
    `CSURJ_ASSERT_IMPLY(a_done_while_idle, clk, rst_n, done, !busy)
    `CSURJ_ASSERT_IMPLY(a_cursor_in_fill, clk, rst_n, 1'b1, cursor_reg <= fill_reg)
    `CSURJ_ASSERT_IMPLY(a_fill_bounded, clk, rst_n, 1'b1, fill_reg <= JCW'(JOURNAL_DEPTH))

endmodule
